### rtl/dcq_pkg.sv
// shared types, codes and constants of the dma command queue
package dcq_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int DATA_IN_W  = 72;
  localparam int DATA_OUT_W = 72;

  localparam logic [17:0] SRC_SPAN = 18'h20000;

  typedef enum logic [2:0] {
    REQ_TRANSFER = 3'd0,
    REQ_SPRITE   = 3'd1,
    REQ_FILL     = 3'd2,
    REQ_COPY     = 3'd3,
    REQ_FETCH    = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    OP_TRANSFER = 2'd0,
    OP_FILL     = 2'd1,
    OP_COPY     = 2'd2,
    OP_SPRITE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RK_ACK  = 2'd0,
    RK_CMD  = 2'd1,
    RK_NONE = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [7:0]  step;
    logic [15:0] length;
    logic [1:0]  target;
    op_t         op;
    logic [22:0] source;
    logic [15:0] dest;
  } cmd_t;

  typedef struct packed {
    logic is_enq;
    logic is_fetch;
    logic split;
    cmd_t hi;
    cmd_t lo;
  } split_t;

endpackage

### rtl/dma_command_queue.sv
// dma command queue top level: stream ports, control sequencer, sprite slots
// a request is captured in S_IDLE, handled in S_WORK (and S_WORK2 if split in
// two) and its result registered once the output is free; no new request is
// taken until then; the ring is written at tail, a fetch reads its registered head
// reset: synchronous active-low rst_n empties ring and sprite slots at once;
// unwritten entries are never read, so the ring memory needs no clearing
module dma_command_queue #(
  parameter int QUEUE_DEPTH = dcq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // target, dest_addr, source, count, step, zero pad
  input  logic [dcq_pkg::DATA_IN_W-1:0]     in_tdata,
  // req_type
  input  logic [2:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cmd_op, cmd_target, cmd_dest, cmd_length, cmd_source, cmd_step,
  // stored_count, dropped, now_empty, zero pad
  output logic [dcq_pkg::DATA_OUT_W-1:0]    out_tdata,
  // result_kind
  output logic [1:0]                        out_tuser
);
  import dcq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_WORK2
  } state_t;

  state_t                  state_r, state_nxt;
  logic [2:0]              req_type_r;
  logic [1:0]              target_r;
  logic [15:0]             dest_r;
  logic [23:0]             source_r;
  logic [15:0]             count_r;
  logic [7:0]              step_r;

  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [PTR_W-1:0]        tail_inc;
  logic [1:0]              slot_valid_r, slot_valid_nxt;
  logic [1:0]              slot_fill_r, slot_fill_nxt;
  cmd_t                    slot_r [2];
  logic                    slot_we;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    drop_r, drop_nxt;

  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [DATA_OUT_W-1:0]   out_data_r;
  logic                    load_out;
  result_kind_t            res_kind;
  cmd_t                    res_cmd;
  logic                    now_empty;

  split_t                  sp;
  cmd_t                    store_rec;
  cmd_t                    ring_rd;
  logic                    ring_we;
  logic                    out_free;
  logic                    final_step;

  dcq_split u_split (
    .req_type  (req_type_r),
    .target    (target_r),
    .dest_addr (dest_r),
    .source    (source_r),
    .count     (count_r),
    .step      (step_r),
    .sp        (sp)
  );

  dcq_ring_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk       (clk),
    .wr_en     (ring_we),
    .wr_addr   (tail_r),
    .wr_data   (store_rec),
    .rd_addr   (head_r),
    .rd_data_r (ring_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_free   = !out_valid_r || out_tready;
  assign tail_inc   = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  assign store_rec  = (state_r == S_WORK && sp.split) ? sp.hi : sp.lo;
  assign final_step = !(state_r == S_WORK && sp.split);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    slot_valid_nxt = slot_valid_r;
    slot_fill_nxt  = slot_fill_r;
    cnt_nxt        = cnt_r;
    drop_nxt       = drop_r;
    ring_we        = 1'b0;
    slot_we        = 1'b0;
    load_out       = 1'b0;
    res_kind       = RK_ACK;
    res_cmd        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_WORK;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
        end
      end
      S_WORK, S_WORK2: begin
        if (!final_step || out_free) begin
          if (sp.is_enq) begin
            if (store_rec.op == OP_SPRITE) begin
              if (slot_fill_r == 2'd2) begin
                drop_nxt = 1'b1;
              end else begin
                slot_we        = 1'b1;
                slot_valid_nxt = slot_valid_r
                               | ((slot_fill_r == 2'd0) ? 2'b01 : 2'b10);
                slot_fill_nxt  = slot_fill_r + 2'd1;
                cnt_nxt        = cnt_r + 2'd1;
              end
            end else if (tail_inc == head_r) begin
              drop_nxt = 1'b1;
            end else begin
              ring_we  = 1'b1;
              tail_nxt = tail_inc;
              cnt_nxt  = cnt_r + 2'd1;
            end
          end else if (sp.is_fetch) begin
            priority if (slot_valid_r[0]) begin
              res_kind          = RK_CMD;
              res_cmd           = slot_r[0];
              slot_valid_nxt[0] = 1'b0;
            end else if (slot_valid_r[1]) begin
              res_kind          = RK_CMD;
              res_cmd           = slot_r[1];
              slot_valid_nxt[1] = 1'b0;
            end else if (head_r != tail_r) begin
              res_kind = RK_CMD;
              res_cmd  = ring_rd;
              head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
            end else begin
              res_kind = RK_NONE;
            end
            if (slot_valid_nxt == 2'b00) begin
              slot_fill_nxt = 2'd0;
            end
          end
          if (final_step) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WORK2;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    now_empty = (slot_valid_nxt == 2'b00) && (head_nxt == tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      slot_valid_r <= '0;
      slot_fill_r  <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      drop_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_fill_r  <= slot_fill_nxt;
      cnt_r        <= cnt_nxt;
      drop_r       <= drop_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, result register and sprite slot write
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_type_r <= in_tuser;
      target_r   <= in_tdata[1:0];
      dest_r     <= in_tdata[17:2];
      source_r   <= in_tdata[41:18];
      count_r    <= in_tdata[57:42];
      step_r     <= in_tdata[65:58];
    end
    if (load_out) begin
      out_kind_r <= res_kind;
      out_data_r <= {1'b0, now_empty,
                     (res_kind == RK_ACK) ? drop_nxt : 1'b0,
                     (res_kind == RK_ACK) ? cnt_nxt : 2'd0,
                     res_cmd.step, res_cmd.source, res_cmd.length,
                     res_cmd.dest, res_cmd.target, res_cmd.op};
    end
    if (slot_we) begin
      slot_r[slot_fill_r[0]] <= store_rec;
    end
  end

endmodule

### rtl/dcq_ring_mem.sv
// simple dual-port ring memory holding queued command records
module dcq_ring_mem #(
  parameter int QUEUE_DEPTH = dcq_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PTR_W-1:0]  wr_addr,
  input  dcq_pkg::cmd_t     wr_data,
  input  logic [PTR_W-1:0]  rd_addr,
  output dcq_pkg::cmd_t     rd_data_r
);
  import dcq_pkg::*;

  cmd_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

### rtl/dcq_split.sv
// request decode, 128 KiB boundary split and command record encoding
module dcq_split (
  input  logic [2:0]       req_type,
  input  logic [1:0]       target,
  input  logic [15:0]      dest_addr,
  input  logic [23:0]      source,
  input  logic [15:0]      count,
  input  logic [7:0]       step,
  output dcq_pkg::split_t  sp
);
  import dcq_pkg::*;

  op_t         op;
  logic        word_op;
  logic [17:0] limit;
  logic [16:0] half;
  logic [24:0] src_hi;
  logic [22:0] src_lo;

  always_comb begin
    unique case (req_type)
      REQ_TRANSFER: op = OP_TRANSFER;
      REQ_SPRITE:   op = OP_SPRITE;
      REQ_FILL:     op = OP_FILL;
      REQ_COPY:     op = OP_COPY;
      default:      op = OP_TRANSFER;
    endcase

    word_op = (op == OP_TRANSFER) || (op == OP_SPRITE);
    limit   = SRC_SPAN - {1'b0, source[16:0]};
    half    = limit[17:1];
    src_hi  = {1'b0, source} + {7'b0, limit};

    unique case (op)
      OP_FILL: src_lo = {15'b0, source[7:0]};
      OP_COPY: src_lo = {7'b0, source[15:0]};
      default: src_lo = source[23:1];
    endcase

    sp.is_enq   = (req_type == REQ_TRANSFER) || (req_type == REQ_SPRITE)
               || (req_type == REQ_FILL) || (req_type == REQ_COPY);
    sp.is_fetch = (req_type == REQ_FETCH);
    sp.split    = sp.is_enq && word_op && ({1'b0, count} > half);

    sp.hi.step   = step;
    sp.hi.length = count - half[15:0];
    sp.hi.target = target;
    sp.hi.op     = op;
    sp.hi.source = src_hi[23:1];
    sp.hi.dest   = dest_addr + limit[15:0];

    sp.lo.step   = step;
    sp.lo.length = sp.split ? half[15:0] : count;
    sp.lo.target = target;
    sp.lo.op     = op;
    sp.lo.source = src_lo;
    sp.lo.dest   = dest_addr;
  end

endmodule
